@@ rtl/ole_pkg.sv @@
`default_nettype none
package ole_pkg;

  // List geometry
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int UPC_W    = 5;

  typedef logic [2:0]       cmd_t;
  typedef logic [1:0]       status_t;
  typedef logic [UPC_W-1:0] upc_t;

  // Command codes
  localparam cmd_t CMD_INSERT_AT  = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_PUSH_FRONT = 3'd2;
  localparam cmd_t CMD_REMOVE     = 3'd3;
  localparam cmd_t CMD_SEARCH     = 3'd4;
  localparam cmd_t CMD_DUMP       = 3'd5;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_POS   = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // Datapath operations, one per microstep
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,       // take the input item
    OP_BACK,        // pos <= count
    OP_FRONT,       // pos <= 0
    OP_PRIME_UP,    // start tail shift: read entry count-1
    OP_SHIFT_UP,    // store[wa] <= rd, step down
    OP_PUT,         // store[pos] <= val, count++
    OP_PRIME_SCAN,  // read entry 0
    OP_SCAN,        // compare walk, one entry per cycle
    OP_SHIFT_DN,    // store[wa] <= rd, step up
    OP_DEC,         // count--
    OP_EMIT,        // single result with status from the microword
    OP_EMIT_HIT,    // search hit result
    OP_EMIT_ELEM    // one dump element
  } op_t;

  // Branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_OUT_BUSY,
    C_FULL,
    C_BAD_POS,
    C_LIST_END,
    C_NO_MATCH,
    C_RM_END,
    C_SU_END,
    C_MORE,
    C_EMPTY,
    C_DISPATCH
  } cond_t;

  // One control word
  typedef struct packed {
    cond_t   cond_a;  // taken first; suppresses op
    upc_t    tgt_a;
    op_t     op;
    status_t st;
    cond_t   cond_b;  // taken after op, else fall through
    upc_t    tgt_b;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic full;
    logic bad_pos;
    logic list_end;
    logic no_match;
    logic rm_end;
    logic su_end;
    logic more;
    logic empty;
  } flags_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t     op;
    status_t st;
    logic    fetch;
  } ctl_t;

  // Microprogram addresses
  localparam upc_t U_FETCH     = 5'd0;
  localparam upc_t U_DECODE    = 5'd1;
  localparam upc_t U_PBACK     = 5'd2;
  localparam upc_t U_PFRONT    = 5'd3;
  localparam upc_t U_INS_CHK   = 5'd4;
  localparam upc_t U_SU_LOOP   = 5'd5;
  localparam upc_t U_PUT       = 5'd6;
  localparam upc_t U_EMIT_OK   = 5'd7;
  localparam upc_t U_SRCH      = 5'd8;
  localparam upc_t U_SRCH_SCAN = 5'd9;
  localparam upc_t U_SRCH_HIT  = 5'd10;
  localparam upc_t U_RM        = 5'd11;
  localparam upc_t U_RM_SCAN   = 5'd12;
  localparam upc_t U_RM_LOOP   = 5'd13;
  localparam upc_t U_RM_DONE   = 5'd14;
  localparam upc_t U_DUMP      = 5'd15;
  localparam upc_t U_DUMP_LOOP = 5'd16;
  localparam upc_t U_DUMP_END  = 5'd17;
  localparam upc_t U_EMIT_FULL = 5'd18;
  localparam upc_t U_EMIT_BAD  = 5'd19;
  localparam upc_t U_EMIT_NF   = 5'd20;

  function automatic uword_t mk(cond_t ca, upc_t ta, op_t op, status_t st,
                                cond_t cb, upc_t tb);
    uword_t w;
    w.cond_a = ca;
    w.tgt_a  = ta;
    w.op     = op;
    w.st     = st;
    w.cond_b = cb;
    w.tgt_b  = tb;
    return w;
  endfunction

  // Control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = mk(C_NEVER, U_FETCH, OP_NONE, ST_OK, C_ALWAYS, U_FETCH);
    unique case (a)
      U_FETCH:     w = mk(C_NO_IN, U_FETCH, OP_LATCH, ST_OK, C_NEVER, U_FETCH);
      U_DECODE:    w = mk(C_NEVER, U_FETCH, OP_NONE, ST_OK, C_DISPATCH, U_FETCH);
      U_PBACK:     w = mk(C_NEVER, U_FETCH, OP_BACK, ST_OK, C_ALWAYS, U_INS_CHK);
      U_PFRONT:    w = mk(C_NEVER, U_FETCH, OP_FRONT, ST_OK, C_ALWAYS, U_INS_CHK);
      U_INS_CHK:   w = mk(C_FULL, U_EMIT_FULL, OP_PRIME_UP, ST_OK,
                          C_BAD_POS, U_EMIT_BAD);
      U_SU_LOOP:   w = mk(C_SU_END, U_PUT, OP_SHIFT_UP, ST_OK, C_ALWAYS, U_SU_LOOP);
      U_PUT:       w = mk(C_NEVER, U_FETCH, OP_PUT, ST_OK, C_NEVER, U_FETCH);
      U_EMIT_OK:   w = mk(C_OUT_BUSY, U_EMIT_OK, OP_EMIT, ST_OK, C_ALWAYS, U_FETCH);
      U_SRCH:      w = mk(C_NEVER, U_FETCH, OP_PRIME_SCAN, ST_OK, C_NEVER, U_FETCH);
      U_SRCH_SCAN: w = mk(C_LIST_END, U_EMIT_NF, OP_SCAN, ST_OK,
                          C_NO_MATCH, U_SRCH_SCAN);
      U_SRCH_HIT:  w = mk(C_OUT_BUSY, U_SRCH_HIT, OP_EMIT_HIT, ST_OK,
                          C_ALWAYS, U_FETCH);
      U_RM:        w = mk(C_NEVER, U_FETCH, OP_PRIME_SCAN, ST_OK, C_NEVER, U_FETCH);
      U_RM_SCAN:   w = mk(C_LIST_END, U_EMIT_NF, OP_SCAN, ST_OK,
                          C_NO_MATCH, U_RM_SCAN);
      U_RM_LOOP:   w = mk(C_RM_END, U_RM_DONE, OP_SHIFT_DN, ST_OK,
                          C_ALWAYS, U_RM_LOOP);
      U_RM_DONE:   w = mk(C_NEVER, U_FETCH, OP_DEC, ST_OK, C_ALWAYS, U_EMIT_OK);
      U_DUMP:      w = mk(C_EMPTY, U_EMIT_OK, OP_PRIME_SCAN, ST_OK, C_NEVER, U_FETCH);
      U_DUMP_LOOP: w = mk(C_OUT_BUSY, U_DUMP_LOOP, OP_EMIT_ELEM, ST_OK,
                          C_MORE, U_DUMP_LOOP);
      U_DUMP_END:  w = mk(C_NEVER, U_FETCH, OP_NONE, ST_OK, C_ALWAYS, U_FETCH);
      U_EMIT_FULL: w = mk(C_OUT_BUSY, U_EMIT_FULL, OP_EMIT, ST_FULL,
                          C_ALWAYS, U_FETCH);
      U_EMIT_BAD:  w = mk(C_OUT_BUSY, U_EMIT_BAD, OP_EMIT, ST_BAD_POS,
                          C_ALWAYS, U_FETCH);
      U_EMIT_NF:   w = mk(C_OUT_BUSY, U_EMIT_NF, OP_EMIT, ST_NOT_FOUND,
                          C_ALWAYS, U_FETCH);
      default:     w = mk(C_NEVER, U_FETCH, OP_NONE, ST_OK, C_ALWAYS, U_FETCH);
    endcase
    return w;
  endfunction

  // Command to entry point
  function automatic upc_t dispatch(cmd_t c);
    upc_t t;
    unique case (c)
      CMD_INSERT_AT:  t = U_INS_CHK;
      CMD_PUSH_BACK:  t = U_PBACK;
      CMD_PUSH_FRONT: t = U_PFRONT;
      CMD_REMOVE:     t = U_RM;
      CMD_SEARCH:     t = U_SRCH;
      CMD_DUMP:       t = U_DUMP;
      default:        t = U_EMIT_OK;
    endcase
    return t;
  endfunction

  function automatic logic cond_hit(cond_t c, flags_t f);
    logic h;
    unique case (c)
      C_NEVER:    h = 1'b0;
      C_ALWAYS:   h = 1'b1;
      C_NO_IN:    h = !f.in_valid;
      C_OUT_BUSY: h = f.out_busy;
      C_FULL:     h = f.full;
      C_BAD_POS:  h = f.bad_pos;
      C_LIST_END: h = f.list_end;
      C_NO_MATCH: h = f.no_match;
      C_RM_END:   h = f.rm_end;
      C_SU_END:   h = f.su_end;
      C_MORE:     h = f.more;
      C_EMPTY:    h = f.empty;
      default:    h = 1'b0;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ole_seq.sv @@
`default_nettype none
module ole_seq (
  input  wire              clk,
  input  wire              rst,
  input  ole_pkg::flags_t  flags,
  input  ole_pkg::cmd_t    cmd,
  output ole_pkg::ctl_t    ctl
);
  import ole_pkg::*;

  upc_t   step;
  upc_t   step_next;
  uword_t uw;
  logic   take_a;
  logic   take_b;

  // Fetch control word, evaluate branches
  always_comb begin
    uw     = ucode(step);
    take_a = cond_hit(uw.cond_a, flags);
    take_b = cond_hit(uw.cond_b, flags);
  end

  // Next step
  always_comb begin
    if (take_a) begin
      step_next = uw.tgt_a;
    end else if (uw.cond_b == C_DISPATCH) begin
      step_next = dispatch(cmd);
    end else if (take_b) begin
      step_next = uw.tgt_b;
    end else begin
      step_next = step + upc_t'(1);
    end
  end

  // Datapath controls; a taken first branch squashes the op
  always_comb begin
    ctl.op    = take_a ? OP_NONE : uw.op;
    ctl.st    = uw.st;
    ctl.fetch = (step == U_FETCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= U_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ordered_list_engine_unit.sv @@
`default_nettype none
// Ordered list engine: keeps an ordered list of up to 32 signed 32-bit values.
// Input channel s_*: one command item per handshake (insert at position,
// push back, push front, remove value, search, dump). s_tuser carries the
// command, s_tdata the value and position.
// Output channel m_*: one result item per command, or one per element for a
// dump, m_tlast on the final one. An empty dump gives one result, valid clear.
// Control is a microprogram; one command is worked at a time. s_tready is high
// only while the sequencer waits at its fetch step. Insert, push front,
// search, remove and dump walk the element store (one read port, one write
// port) one entry per cycle; a dump's walk holds while the output is busy.
// A result sits in an output register, so the next item is taken while the
// last result still waits.
// When m_tready is low, the sequencer holds at its emit step until the output
// register frees; nothing is lost or repeated.
// Reset (rst, synchronous) empties the list and drops any pending result;
// s_tready stays low while rst is high.
module ordered_list_engine_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [2:0]  s_tuser,   // command
  input  wire  [39:0] s_tdata,   // data_value[31:0], position[39:32]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // status[1:0], found_position[6:2],
                                 // element_value[38:7], element_valid[39],
                                 // length[45:40], zero pad[47:46]
  output logic        m_tlast
);
  import ole_pkg::*;

  flags_t flags;
  ctl_t   ctl;

  // Working registers
  cmd_t                    cmd;
  logic signed [VAL_W-1:0] val;
  logic [POS_W-1:0]        pos;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_m1;
  logic [CNT_W-1:0]        ra;
  logic [CNT_W-1:0]        wa;
  logic [CNT_W-1:0]        ca;
  logic [CNT_W-1:0]        ca_p1;
  logic [CNT_W-1:0]        fidx;

  // Element store
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    re;
  logic [ADDR_W-1:0]       raddr;

  // Output register
  logic                    o_valid;
  status_t                 o_status;
  logic [4:0]              o_fpos;
  logic signed [VAL_W-1:0] o_value;
  logic                    o_evalid;
  logic [5:0]              o_len;
  logic                    o_last;

  ole_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cmd   (cmd),
    .ctl   (ctl)
  );

  assign cnt_m1 = cnt - CNT_W'(1);
  assign ca_p1  = ca + CNT_W'(1);

  // Status flags for the sequencer
  always_comb begin
    flags.in_valid = s_tvalid;
    flags.out_busy = o_valid && !m_tready;
    flags.full     = (cnt >= CNT_W'(CAPACITY));
    flags.bad_pos  = (pos > POS_W'(cnt));
    flags.list_end = (ca == cnt);
    flags.no_match = (rd_data != val);
    flags.rm_end   = ((wa + CNT_W'(1)) == cnt);
    flags.su_end   = (POS_W'(wa) == pos);
    flags.more     = (ca_p1 != cnt);
    flags.empty    = (cnt == '0);
  end

  // Store port control
  always_comb begin
    we    = 1'b0;
    waddr = wa[ADDR_W-1:0];
    wdata = rd_data;
    re    = 1'b0;
    raddr = ra[ADDR_W-1:0];
    case (ctl.op)
      OP_PRIME_UP: begin
        re    = 1'b1;
        raddr = cnt_m1[ADDR_W-1:0];
      end
      OP_SHIFT_UP, OP_SHIFT_DN: begin
        we = 1'b1;
        re = 1'b1;
      end
      OP_PUT: begin
        we    = 1'b1;
        waddr = pos[ADDR_W-1:0];
        wdata = val;
      end
      OP_PRIME_SCAN: begin
        re    = 1'b1;
        raddr = '0;
      end
      OP_SCAN, OP_EMIT_ELEM: begin
        re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  // Count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      case (ctl.op)
        OP_PUT:  cnt <= cnt + CNT_W'(1);
        OP_DEC:  cnt <= cnt_m1;
        default: begin
        end
      endcase
      // a new result replaces the one taken at this edge
      case (ctl.op)
        OP_EMIT, OP_EMIT_HIT, OP_EMIT_ELEM: o_valid <= 1'b1;
        default: begin
          if (m_tready) begin
            o_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  // Walk pointers and item fields
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        cmd <= s_tuser;
        val <= s_tdata[31:0];
        pos <= s_tdata[39:32];
      end
      OP_BACK:  pos <= POS_W'(cnt);
      OP_FRONT: pos <= '0;
      OP_PRIME_UP: begin
        ra <= cnt_m1 - CNT_W'(1);
        wa <= cnt;
      end
      OP_SHIFT_UP: begin
        ra <= ra - CNT_W'(1);
        wa <= wa - CNT_W'(1);
      end
      OP_PRIME_SCAN: begin
        ra <= CNT_W'(1);
        ca <= '0;
      end
      OP_SCAN: begin
        fidx <= ca;
        wa   <= ca;
        ra   <= ra + CNT_W'(1);
        ca   <= ca_p1;
      end
      OP_SHIFT_DN: begin
        ra <= ra + CNT_W'(1);
        wa <= wa + CNT_W'(1);
      end
      OP_EMIT_ELEM: begin
        ra <= ra + CNT_W'(1);
        ca <= ca_p1;
      end
      default: begin
      end
    endcase
  end

  // Result payload
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_EMIT: begin
        o_status <= ctl.st;
        o_fpos   <= '0;
        o_value  <= '0;
        o_evalid <= 1'b0;
        o_len    <= 6'(cnt);
        o_last   <= 1'b1;
      end
      OP_EMIT_HIT: begin
        o_status <= ST_OK;
        o_fpos   <= 5'(fidx);
        o_value  <= '0;
        o_evalid <= 1'b0;
        o_len    <= 6'(cnt);
        o_last   <= 1'b1;
      end
      OP_EMIT_ELEM: begin
        o_status <= ST_OK;
        o_fpos   <= '0;
        o_value  <= rd_data;
        o_evalid <= 1'b1;
        o_len    <= 6'(cnt);
        o_last   <= !flags.more;
      end
      default: begin
      end
    endcase
  end

  assign s_tready = ctl.fetch && !rst;
  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {2'b00, o_len, o_evalid, o_value, o_fpos, o_status};

endmodule
`default_nettype wire
